@@ design/ct_delta_row_decompressor_defines.svh @@
// Assertion macros for the delta row decompressor.
`ifndef CT_DELTA_ROW_DECOMPRESSOR_DEFINES_SVH
`define CT_DELTA_ROW_DECOMPRESSOR_DEFINES_SVH

`ifndef SYNTH
`define CTDR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CTDR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTDR_ASSERT(lbl, clk, rst, prop, msg)
`define CTDR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ design/ctdr_pkg.sv @@
// Types and constants shared by the delta row decompressor.
package ctdr_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = 11;
  localparam int HALF_W    = 10;
  localparam int PIX_W     = 12;
  localparam int BYTE_W    = 8;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;

  localparam logic [COL_W-1:0] MAX_COL = COL_W'(MAX_WIDTH);

  localparam logic CMD_ROW_START = 1'b0;
  localparam logic CMD_DATA      = 1'b1;

  localparam logic [0:0] REG_ROW_WIDTH = 1'b0;
  localparam logic [0:0] REG_USE_MAP   = 1'b1;

  localparam logic [1:0] PUSH_NONE = 2'd0;
  localparam logic [1:0] PUSH_ONE  = 2'd1;
  localparam logic [1:0] PUSH_TWO  = 2'd2;

  typedef struct packed {
    logic [COL_W-1:0] row_width;
    logic             use_map;
  } ctdr_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic [COL_W-1:0] run_length;
    logic             row_end;
  } ctdr_result_t;

  typedef struct packed {
    logic [1:0]   count;
    ctdr_result_t r0;
    ctdr_result_t r1;
  } ctdr_push_t;

endpackage

@@ design/ctdr_stream_if.sv @@
// Valid/ready channel interfaces for input bytes and result runs.
interface ctdr_in_if;
  import ctdr_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [HALF_W-1:0] half_length;
  logic [BYTE_W-1:0] data_byte;
  modport source(output valid, cmd, half_length, data_byte, input ready);
  modport sink(input valid, cmd, half_length, data_byte, output ready);
endinterface

interface ctdr_out_if;
  import ctdr_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic [COL_W-1:0] run_length;
  logic             row_end;
  modport source(output valid, pixel_value, run_length, row_end, input ready);
  modport sink(input valid, pixel_value, run_length, row_end, output ready);
endinterface

@@ design/ctdr_decode.sv @@
// Input register, row/pixel state and single-pass decode of one byte.
module ctdr_decode (
  input  logic                clk,
  input  logic                rst,
  ctdr_in_if.sink             din,
  input  ctdr_pkg::ctdr_cfg_t cfg,
  input  logic                space_ok,
  output ctdr_pkg::ctdr_push_t push
);
  import ctdr_pkg::*;

  logic              s_valid;
  logic              s_cmd;
  logic [HALF_W-1:0] s_half;
  logic [BYTE_W-1:0] s_byte;

  logic [PIX_W-1:0]  previous_pixel, previous_pixel_next;
  logic              literal_pending, literal_pending_next;
  logic [6:0]        literal_high, literal_high_next;
  logic [COL_W-1:0]  column, column_next;
  logic [COL_W-1:0]  middle_end, middle_end_next;
  logic              in_middle, in_middle_next;

  logic              advance;
  logic [COL_W-1:0]  w;
  logic [HALF_W-1:0] half_w, hl, start;
  logic [COL_W-1:0]  start_c, end_c, col_inc;
  logic [PIX_W-1:0]  pix;

  assign advance   = s_valid && space_ok;
  assign din.ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (din.valid && din.ready) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
    if (din.valid && din.ready) begin
      s_cmd  <= din.cmd;
      s_half <= din.half_length;
      s_byte <= din.data_byte;
    end
  end

  always_comb begin
    if (cfg.row_width == '0) begin
      w = COL_W'(1);
    end else if (cfg.row_width > MAX_COL) begin
      w = MAX_COL;
    end else begin
      w = cfg.row_width;
    end
    half_w  = w[COL_W-1:1];
    hl      = (s_half > half_w) ? half_w : s_half;
    start   = half_w - hl;
    start_c = cfg.use_map ? {1'b0, start} : '0;
    end_c   = cfg.use_map ? ({1'b0, start} + {hl, 1'b0}) : w;
    col_inc = column + COL_W'(1);
  end

  always_comb begin
    previous_pixel_next  = previous_pixel;
    literal_pending_next = literal_pending;
    literal_high_next    = literal_high;
    column_next          = column;
    middle_end_next      = middle_end;
    in_middle_next       = in_middle;
    pix                  = previous_pixel;
    push                 = '0;
    push.count           = PUSH_NONE;
    if (s_cmd == CMD_ROW_START) begin
      literal_pending_next = 1'b0;
      literal_high_next    = '0;
      column_next          = start_c;
      middle_end_next      = end_c;
      in_middle_next       = (start_c < end_c);
      if (start_c != '0) begin
        push.r0    = '{pixel_value: '0, run_length: start_c, row_end: 1'b0};
        push.count = PUSH_ONE;
        if (start_c >= end_c) begin
          push.r1    = '{pixel_value: '0, run_length: w - end_c, row_end: 1'b1};
          push.count = PUSH_TWO;
        end
      end else if (start_c >= end_c) begin
        push.r0    = '{pixel_value: '0, run_length: w - end_c, row_end: 1'b1};
        push.count = PUSH_ONE;
      end
    end else if (in_middle) begin
      if (literal_pending || s_byte[7]) begin
        if (literal_pending) begin
          pix = {literal_high[3:0], s_byte};
        end else if (s_byte[6]) begin
          pix = previous_pixel + {4'hf, s_byte};
        end else begin
          pix = previous_pixel + {6'd0, s_byte[5:0]};
        end
        previous_pixel_next  = pix;
        literal_pending_next = 1'b0;
        column_next          = col_inc;
        push.r0    = '{pixel_value: pix, run_length: COL_W'(1), row_end: 1'b0};
        push.count = PUSH_ONE;
        if (col_inc >= middle_end) begin
          in_middle_next = 1'b0;
          if (middle_end < w) begin
            push.r1    = '{pixel_value: '0, run_length: w - middle_end, row_end: 1'b1};
            push.count = PUSH_TWO;
          end else begin
            push.r0.row_end = 1'b1;
          end
        end
      end else begin
        literal_high_next    = s_byte[6:0];
        literal_pending_next = 1'b1;
      end
    end
    if (!advance) begin
      push.count = PUSH_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_pixel  <= '0;
      literal_pending <= 1'b0;
      literal_high    <= '0;
      column          <= '0;
      middle_end      <= '0;
      in_middle       <= 1'b0;
    end else if (advance) begin
      previous_pixel  <= previous_pixel_next;
      literal_pending <= literal_pending_next;
      literal_high    <= literal_high_next;
      column          <= column_next;
      middle_end      <= middle_end_next;
      in_middle       <= in_middle_next;
    end
  end

endmodule

@@ design/ctdr_result_fifo.sv @@
// Four-entry result queue taking up to two runs per cycle.
module ctdr_result_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  ctdr_pkg::ctdr_push_t push,
  output logic                 space_ok,
  ctdr_out_if.source           dout
);
  import ctdr_pkg::*;

  ctdr_result_t      entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              pop;

  assign pop              = dout.valid && dout.ready;
  assign dout.valid       = (count != '0);
  assign dout.pixel_value = entries[rd_ptr].pixel_value;
  assign dout.run_length  = entries[rd_ptr].run_length;
  assign dout.row_end     = entries[rd_ptr].row_end;
  assign space_ok         = (count <= QCNT_W'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      count  <= count + QCNT_W'(push.count) - QCNT_W'(pop);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
    end
    if (push.count != PUSH_NONE) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.count == PUSH_TWO) begin
      entries[wr_ptr + QPTR_W'(1)] <= push.r1;
    end
  end

endmodule

@@ design/ct_delta_row_decompressor.sv @@
// Delta row decompressor: byte stream in, run-length pixel runs out, one item per
// clock. An accepted item is held in an input register and decoded in a single
// pass into zero, one or two runs, which go into a four-entry result queue; the
// first run is presented on the output from the head of that queue.
// Input is taken every cycle while the queue has two free entries, so with the
// output draining one run per cycle the rate is one item per cycle, and only items
// that give two runs (row starts with a leading run and an empty middle, the last
// byte of a row middle followed by a trailing run) can briefly stall it.
// Registers: row_width at address 0, use_map at address 4.
`include "ct_delta_row_decompressor_defines.svh"

module ct_delta_row_decompressor (
  input  logic        clk,
  input  logic        rst,
  ctdr_in_if.sink     din,
  ctdr_out_if.source  dout,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ctdr_pkg::*;

  ctdr_cfg_t  cfg;
  ctdr_push_t push;
  logic       space_ok;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_width <= COL_W'(512);
      cfg.use_map   <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_ROW_WIDTH: cfg.row_width <= pwdata[COL_W-1:0];
        REG_USE_MAP:   cfg.use_map   <= pwdata[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROW_WIDTH: prdata = {{(32-COL_W){1'b0}}, cfg.row_width};
      REG_USE_MAP:   prdata = {31'd0, cfg.use_map};
      default:       prdata = '0;
    endcase
  end

  ctdr_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .din      (din),
    .cfg      (cfg),
    .space_ok (space_ok),
    .push     (push)
  );

  ctdr_result_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space_ok (space_ok),
    .dout     (dout)
  );

  `CTDR_ASSERT(a_push_needs_space, clk, rst, (push.count != PUSH_NONE) |-> space_ok, "push without queue space")
  `CTDR_ASSERT(a_row_end_last, clk, rst, (push.count == PUSH_TWO) |-> !push.r0.row_end, "row end not on last run")
  `CTDR_ASSERT(a_push_count, clk, rst, push.count <= PUSH_TWO, "bad push count")
  `CTDR_ASSERT_ALWAYS(a_empty_after_reset, clk, $past(rst) |-> !dout.valid, "output valid after reset")

endmodule

@@ bench/ctdr_run_checker.sv @@
`timescale 1ns / 100ps
// Checker for the delta row decompressor: predicts runs from accepted transactions and compares.
module ctdr_run_checker (
  input  logic        clk,
  input  logic        rst,
  ctdr_in_if          din,
  ctdr_out_if         dout,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          runs_waiting
);
  import ctdr_pkg::*;

  logic [COL_W-1:0] row_width;
  logic             map_on;
  logic [PIX_W-1:0] pixel;
  logic             literal_open;
  logic [6:0]       literal_top;
  logic [COL_W-1:0] column;
  logic [COL_W-1:0] middle_stop;
  logic             decoding;
  ctdr_result_t     expected_runs[$];
  ctdr_result_t     want;

  function automatic logic [COL_W-1:0] active_width();
    if (row_width == '0) return COL_W'(1);
    if (row_width > MAX_COL) return MAX_COL;
    return row_width;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic expect_run(input logic [PIX_W-1:0] value, input logic [COL_W-1:0] length,
                            input logic last);
    ctdr_result_t r;
    r.pixel_value = value;
    r.run_length  = length;
    r.row_end     = last;
    expected_runs.push_back(r);
  endtask

  task automatic predict_runs(input logic cmd, input logic [HALF_W-1:0] half,
                              input logic [BYTE_W-1:0] code);
    logic [COL_W-1:0] w;
    logic [COL_W-1:0] span;
    logic [COL_W-1:0] first;
    logic [COL_W-1:0] stop;
    w = active_width();
    if (cmd == CMD_ROW_START) begin
      literal_open = 1'b0;
      literal_top  = '0;
      if (map_on) begin
        span  = ({1'b0, half} > (w >> 1)) ? (w >> 1) : {1'b0, half};
        first = (w >> 1) - span;
        stop  = first + (span << 1);
      end else begin
        first = '0;
        stop  = w;
      end
      column      = first;
      middle_stop = stop;
      if (first != '0) expect_run('0, first, 1'b0);
      decoding = (first < stop);
      if (!decoding) expect_run('0, w - stop, 1'b1);
    end else if (decoding) begin
      if (literal_open) begin
        pixel        = {literal_top[3:0], code};
        literal_open = 1'b0;
      end else if (code[7] && code[6]) begin
        pixel = pixel + {4'hF, code};
      end else if (code[7]) begin
        pixel = pixel + {6'b0, code[5:0]};
      end else begin
        literal_top  = code[6:0];
        literal_open = 1'b1;
      end
      if (!literal_open) begin
        column = column + 1'b1;
        if (column >= middle_stop) begin
          decoding = 1'b0;
          if (middle_stop < w) begin
            expect_run(pixel, COL_W'(1), 1'b0);
            expect_run('0, w - middle_stop, 1'b1);
          end else begin
            expect_run(pixel, COL_W'(1), 1'b1);
          end
        end else begin
          expect_run(pixel, COL_W'(1), 1'b0);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      row_width    = 11'd512;
      map_on       = 1'b1;
      pixel        = '0;
      literal_open = 1'b0;
      literal_top  = '0;
      column       = '0;
      middle_stop  = '0;
      decoding     = 1'b0;
      fail_count   = 0;
      expected_runs.delete();
    end else begin
      if (dout.valid && dout.ready) begin
        if (expected_runs.size() == 0) begin
          report_mismatch($sformatf("unexpected run pixel %0d length %0d end %0b",
                                    dout.pixel_value, dout.run_length, dout.row_end));
        end else begin
          want = expected_runs.pop_front();
          if (dout.pixel_value !== want.pixel_value)
            report_mismatch($sformatf("pixel_value %0d, predicted %0d",
                                      dout.pixel_value, want.pixel_value));
          if (dout.run_length !== want.run_length)
            report_mismatch($sformatf("run_length %0d, predicted %0d",
                                      dout.run_length, want.run_length));
          if (dout.row_end !== want.row_end)
            report_mismatch($sformatf("row_end %0b, predicted %0b",
                                      dout.row_end, want.row_end));
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_ROW_WIDTH, 2'b00}) row_width = pwdata[COL_W-1:0];
        else if (paddr == {REG_USE_MAP, 2'b00}) map_on = pwdata[0];
      end
      if (din.valid && din.ready)
        predict_runs(din.cmd, din.half_length, din.data_byte);
    end
    runs_waiting = expected_runs.size();
  end

endmodule

@@ bench/tb_ct_delta_row_decompressor.sv @@
`timescale 1ns / 100ps
// Testbench top for the delta row decompressor: clock, reset, stimulus, register set-up, verdict.
module tb_ct_delta_row_decompressor;
  import ctdr_pkg::*;

  localparam int ITEM_TARGET = 1850;
  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          runs_waiting;
  int          items_sent;
  int          hold_cycles = 0;
  int          quiet_cycles = 0;
  int          width_now;
  logic        map_now;
  logic        calm;
  logic        jitter_on;

  ctdr_in_if  din();
  ctdr_out_if dout();

  ct_delta_row_decompressor dut (
    .clk     (clk),
    .rst     (rst),
    .din     (din),
    .dout    (dout),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ctdr_run_checker chk (
    .clk          (clk),
    .rst          (rst),
    .din          (din),
    .dout         (dout),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .runs_waiting (runs_waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      dout.ready  <= 1'b0;
    end else if (jitter_on && !calm && $urandom_range(0, 4) == 0) begin
      hold_cycles <= $urandom_range(0, 2);
      dout.ready  <= 1'b0;
    end else begin
      dout.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (din.valid && din.ready) || (dout.valid && dout.ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL ct_delta_row_decompressor");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic cmd, input logic [HALF_W-1:0] half,
                           input logic [BYTE_W-1:0] code);
    if (jitter_on && !calm && $urandom_range(0, 4) == 0) begin
      din.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    din.valid       <= 1'b1;
    din.cmd         <= cmd;
    din.half_length <= half;
    din.data_byte   <= code;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_pixel();
    case ($urandom_range(0, 3))
      0: send_item(CMD_DATA, HALF_W'($urandom), {2'b11, 6'($urandom)});
      1: send_item(CMD_DATA, HALF_W'($urandom), {2'b10, 6'($urandom)});
      default: begin
        send_item(CMD_DATA, HALF_W'($urandom), {1'b0, 7'($urandom)});
        send_item(CMD_DATA, HALF_W'($urandom), BYTE_W'($urandom));
      end
    endcase
  endtask

  // wait for every predicted run, then let any result-free transaction clear the pipe
  task automatic settle();
    din.valid <= 1'b0;
    while (runs_waiting != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input int width_raw, input logic map);
    settle();
    write_reg({REG_ROW_WIDTH, 2'b00}, ($urandom & 32'hFFFF_F800) | (32'(width_raw) & 32'h7FF));
    write_reg({REG_USE_MAP, 2'b00}, ($urandom & 32'hFFFF_FFFE) | 32'(map));
    width_now = (width_raw == 0) ? 1 : (width_raw > MAX_WIDTH) ? MAX_WIDTH : width_raw;
    map_now   = map;
  endtask

  function automatic int middle_pixels(input int half);
    if (!map_now) return width_now;
    return 2 * ((half > width_now / 2) ? width_now / 2 : half);
  endfunction

  initial begin
    int width_pick;
    int half_pick;
    int pixels;
    rst             = 1'b1;
    din.valid       = 1'b0;
    din.cmd         = CMD_DATA;
    din.half_length = '0;
    din.data_byte   = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    items_sent      = 0;
    width_now       = 512;
    map_now         = 1'b1;
    calm            = 1'b0;
    jitter_on       = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: width 512, map mode
    send_item(CMD_ROW_START, 10'd0, BYTE_W'($urandom));
    send_item(CMD_ROW_START, 10'h3FF, BYTE_W'($urandom));
    send_item(CMD_DATA, HALF_W'($urandom), 8'hFF);
    send_item(CMD_DATA, HALF_W'($urandom), 8'hC0);
    send_item(CMD_DATA, HALF_W'($urandom), 8'h80);
    send_item(CMD_DATA, HALF_W'($urandom), 8'hBF);
    send_item(CMD_DATA, HALF_W'($urandom), 8'h7F);
    send_item(CMD_DATA, HALF_W'($urandom), 8'hFF);
    send_item(CMD_DATA, HALF_W'($urandom), 8'h00);
    send_item(CMD_DATA, HALF_W'($urandom), 8'h00);
    send_item(CMD_DATA, HALF_W'($urandom), 8'h45);
    send_item(CMD_ROW_START, 10'd1, BYTE_W'($urandom));
    send_item(CMD_DATA, HALF_W'($urandom), 8'hC1);
    send_item(CMD_DATA, HALF_W'($urandom), 8'h81);
    send_item(CMD_DATA, HALF_W'($urandom), 8'h90);

    configure(0, 1'b0);
    send_item(CMD_ROW_START, HALF_W'($urandom), BYTE_W'($urandom));
    send_item(CMD_DATA, HALF_W'($urandom), 8'h3A);
    send_item(CMD_DATA, HALF_W'($urandom), 8'h12);

    configure(1, 1'b1);
    send_item(CMD_ROW_START, 10'd5, BYTE_W'($urandom));

    // widen mid-row: long trailing run
    configure(2, 1'b0);
    send_item(CMD_ROW_START, HALF_W'($urandom), BYTE_W'($urandom));
    configure(2047, 1'b0);
    send_item(CMD_DATA, HALF_W'($urandom), 8'hC2);
    send_item(CMD_DATA, HALF_W'($urandom), 8'h83);

    // narrow mid-row: last pixel closes the row
    configure(1025, 1'b1);
    send_item(CMD_ROW_START, 10'd1, BYTE_W'($urandom));
    send_item(CMD_DATA, HALF_W'($urandom), 8'h81);
    configure(40, 1'b1);
    send_item(CMD_DATA, HALF_W'($urandom), 8'h82);
    send_item(CMD_ROW_START, 10'h200, BYTE_W'($urandom));
    send_item(CMD_DATA, HALF_W'($urandom), 8'hEE);

    while (items_sent < ITEM_TARGET) begin
      jitter_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       width_pick = 0;
        1:       width_pick = 1;
        2:       width_pick = MAX_WIDTH;
        3:       width_pick = $urandom_range(MAX_WIDTH + 1, 2047);
        4, 5:    width_pick = $urandom_range(2, 16);
        default: width_pick = $urandom_range(2, 64);
      endcase
      configure(width_pick, 1'($urandom));
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 4)) send_item(CMD_DATA, HALF_W'($urandom), BYTE_W'($urandom));
      repeat ($urandom_range(2, 8)) begin
        calm = (items_sent >= ITEM_TARGET - 300);
        if ($urandom_range(0, 11) == 0)
          send_item(CMD_DATA, HALF_W'($urandom), BYTE_W'($urandom));
        half_pick = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 24);
        pixels = middle_pixels(half_pick);
        if (pixels > 80) pixels = $urandom_range(0, 80);
        else if ($urandom_range(0, 9) == 0) pixels = $urandom_range(0, pixels);
        send_item(CMD_ROW_START, HALF_W'(half_pick), BYTE_W'($urandom));
        repeat (pixels) send_pixel();
      end
    end

    calm = 1'b1;
    settle();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && runs_waiting == 0) begin
      $display("PASS ct_delta_row_decompressor");
    end else begin
      $display("FAIL ct_delta_row_decompressor");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/ctdr_pkg.sv
design/ctdr_stream_if.sv
design/ctdr_decode.sv
design/ctdr_result_fifo.sv
design/ct_delta_row_decompressor.sv
bench/ctdr_run_checker.sv
bench/tb_ct_delta_row_decompressor.sv
